FILE: sv/sfed_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfed_pkg: shared types and constants for the sensor frame edge decoder
// Command and status codes, frame geometry and the frame state record.
// ----------------------------------------------------------------------------
package sfed_pkg;

  // Frame geometry
  localparam int          EdgeCountW   = 7;
  localparam int          TimeW        = 32;
  localparam int          ThreshW      = 16;
  localparam int          FrameBitsW   = 40;
  localparam logic [6:0]  MAX_EDGES    = 7'd100;
  localparam logic [6:0]  FRAME_EDGES  = 7'd43;
  localparam logic [6:0]  FIRST_BIT_EDGE = 7'd3;
  localparam logic [15:0] THRESH_RESET = 16'd100;

  // Input command codes (tuser)
  typedef enum logic [1:0] {
    CMD_START = 2'd0,
    CMD_EDGE  = 2'd1,
    CMD_END   = 2'd2
  } cmd_t;

  // Result status codes (tuser)
  typedef enum logic [1:0] {
    STATUS_OK           = 2'd0,
    STATUS_COUNT_ERR    = 2'd1,
    STATUS_CHECKSUM_ERR = 2'd2
  } status_t;

  // Current frame contents, seen by the report builder
  typedef struct packed {
    logic [EdgeCountW-1:0] edge_count;
    logic [FrameBitsW-1:0] frame_bits;
  } frame_state_t;

  // One processed item, handed from the input stage to the frame and report logic
  typedef struct packed {
    logic             start;
    logic             edge_hit;
    logic             finish;
    logic [TimeW-1:0] edge_time;
  } item_ctl_t;

endpackage

FILE: sv/sensor_frame_edge_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sensor_frame_edge_decoder: single-bus humidity/temperature frame decoder
// Decodes a sensor frame from falling-edge timestamps and reports it on end.
//
//  channel  dir  handshake          payload
//  s_*      in   s_tvalid/s_tready  tuser: command; tdata: edge_time
//  m_*      out  m_tvalid/m_tready  tuser: status; tdata: report fields
//  cfg_*    in   cfg_valid/cfg_ready cfg_data: bit_threshold
//
// One item per cycle sustained: input register, then one subtract/compare
// and shift (or checksum add) into the frame state or result register.
// Reset (rst, synchronous) clears the frame and sets bit_threshold to 100.
// An end command waits in the input register while the result register is
// full and not taken; other commands pass regardless of m_tready.
// ----------------------------------------------------------------------------
module sensor_frame_edge_decoder import sfed_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // edge_time
  input  logic [1:0]  s_tuser,   // command
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // edges_seen, humidity_whole, humidity_tenths,
                                 // temperature_whole, temperature_tenths,
                                 // below_zero, check_byte, 1 pad bit
  output logic [1:0]  m_tuser,   // status
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data   // bit_threshold
);

  logic               in_valid;
  logic [1:0]         in_cmd;
  logic [TimeW-1:0]   in_time;
  logic [ThreshW-1:0] bit_threshold;
  logic               out_free;
  logic               proc;
  item_ctl_t          item;
  frame_state_t       frame;

  // Item in the input register is processed unless it is a blocked end
  assign proc     = in_valid && ((in_cmd != CMD_END) || out_free);
  assign s_tready = !in_valid || proc;

  assign item.start     = proc && (in_cmd == CMD_START);
  assign item.edge_hit  = proc && (in_cmd == CMD_EDGE);
  assign item.finish    = proc && (in_cmd == CMD_END);
  assign item.edge_time = in_time;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (proc) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_cmd  <= s_tuser;
      in_time <= s_tdata;
    end
  end

  // Threshold register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      bit_threshold <= THRESH_RESET;
    end else if (cfg_valid && cfg_ready) begin
      bit_threshold <= cfg_data;
    end
  end

  sfed_frame u_frame (
    .clk           (clk),
    .rst           (rst),
    .item          (item),
    .bit_threshold (bit_threshold),
    .frame         (frame)
  );

  sfed_report u_report (
    .clk      (clk),
    .rst      (rst),
    .load     (item.finish),
    .frame    (frame),
    .out_free (out_free),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule

FILE: sv/sfed_frame.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfed_frame: frame state and bit slicer
// Counts falling edges, keeps the last timestamp and shifts in one data bit
// per edge for edges 3 to 42 from the interval against the bit threshold.
// ----------------------------------------------------------------------------
module sfed_frame import sfed_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  item_ctl_t          item,
  input  logic [ThreshW-1:0] bit_threshold,
  output frame_state_t       frame
);

  logic [EdgeCountW-1:0] edge_count;
  logic [TimeW-1:0]      previous_time;
  logic [FrameBitsW-1:0] frame_bits;

  logic [TimeW-1:0] interval;
  logic             data_bit;
  logic             in_data_window;
  logic             below_limit;

  // Interval since the previous edge, read as signed; negative gives zero
  assign interval       = item.edge_time - previous_time;
  assign data_bit       = !interval[TimeW-1] &&
                          (interval >= {{(TimeW-ThreshW){1'b0}}, bit_threshold});
  assign in_data_window = (edge_count >= FIRST_BIT_EDGE) && (edge_count < FRAME_EDGES);
  assign below_limit    = (edge_count < MAX_EDGES);

  // Frame state update
  always_ff @(posedge clk) begin
    if (rst) begin
      edge_count    <= '0;
      previous_time <= '0;
      frame_bits    <= '0;
    end else if (item.start) begin
      edge_count    <= '0;
      previous_time <= '0;
      frame_bits    <= '0;
    end else if (item.edge_hit && below_limit) begin
      if (in_data_window) begin
        frame_bits <= {frame_bits[FrameBitsW-2:0], data_bit};
      end
      previous_time <= item.edge_time;
      edge_count    <= edge_count + 7'd1;
    end
  end

  assign frame.edge_count = edge_count;
  assign frame.frame_bits = frame_bits;

  // Checks
  a_count_limit: assert property (@(posedge clk) disable iff (rst)
    edge_count <= MAX_EDGES)
    else $error("edge count above limit");

  a_start_clears: assert property (@(posedge clk) disable iff (rst)
    item.start |=> (edge_count == '0) && (frame_bits == '0))
    else $error("start did not clear frame");

  a_limit_holds: assert property (@(posedge clk) disable iff (rst)
    (item.edge_hit && !item.start && edge_count == MAX_EDGES) |=>
      $stable(edge_count) && $stable(previous_time))
    else $error("edge at limit changed state");

endmodule

FILE: sv/sfed_report.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfed_report: frame report builder and result register
// Checks edge count and byte-sum checksum, splits the frame into fields and
// holds the result until the downstream side takes it.
// ----------------------------------------------------------------------------
module sfed_report import sfed_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         load,
  input  frame_state_t frame,
  output logic         out_free,
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [47:0]  m_tdata,   // edges_seen, humidity_whole, humidity_tenths,
                                  // temperature_whole, temperature_tenths,
                                  // below_zero, check_byte, 1 pad bit
  output logic [1:0]   m_tuser    // status
);

  logic [7:0] hu, hl, tu, tl, cb;
  logic [7:0] byte_sum;
  logic       count_ok;
  status_t    status_next;
  logic [47:0] data_next;

  // Byte split and checksum
  assign hu       = frame.frame_bits[39:32];
  assign hl       = frame.frame_bits[31:24];
  assign tu       = frame.frame_bits[23:16];
  assign tl       = frame.frame_bits[15:8];
  assign cb       = frame.frame_bits[7:0];
  assign byte_sum = hu + hl + tu + tl;
  assign count_ok = (frame.edge_count == FRAME_EDGES);

  // Result fields; a bad edge count zeroes the data fields
  always_comb begin
    if (!count_ok) begin
      status_next = STATUS_COUNT_ERR;
      data_next   = {41'd0, frame.edge_count};
    end else begin
      status_next = (byte_sum != cb) ? STATUS_CHECKSUM_ERR : STATUS_OK;
      data_next   = {1'b0, cb, tl[7], tl[6:0], tu, hl, hu, frame.edge_count};
    end
  end

  assign out_free = !m_tvalid || m_tready;

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_tdata <= data_next;
      m_tuser <= status_next;
    end
  end

  // Checks
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    load |-> out_free)
    else $error("result overwritten before transfer");

  a_ok_count: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser != STATUS_COUNT_ERR) |-> (m_tdata[6:0] == FRAME_EDGES))
    else $error("decoded result with wrong edge count");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == STATUS_COUNT_ERR) |-> (m_tdata[47:7] == '0))
    else $error("count error result carries data");

endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for sensor_frame_edge_decoder
// Feeds frames of falling-edge timestamps (well-formed, short, long, saturating
// and noisy) with random sender bursts and receiver stalls. The bench decodes
// every accepted command itself, queues the frame report it expects, and checks
// each report transfer against it field by field.
// ----------------------------------------------------------------------------
module tb_top;
  import sfed_pkg::*;

  localparam logic [1:0] CMD_UNUSED   = 2'd3;  // command value the block ignores
  localparam int         DRAIN_CYCLES = 4;     // two-stage pipeline plus margin
  localparam int         STALL_LIMIT  = 1000;  // cycles without any transfer
  localparam int         ITEM_GOAL    = 1700;
  localparam int         REPORT_GOAL  = 40;

  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_BURSTY} rx_mode_t;

  typedef struct {
    status_t     status;
    logic [6:0]  edges_seen;
    logic [7:0]  humidity_whole;
    logic [7:0]  humidity_tenths;
    logic [7:0]  temperature_whole;
    logic [6:0]  temperature_tenths;
    logic        below_zero;
    logic [7:0]  check_byte;
  } frame_report_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [31:0] s_tdata;   // edge_time
  logic [1:0]  s_tuser;   // command
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [47:0] m_tdata;   // edges_seen, humidity_whole, humidity_tenths,
                          // temperature_whole, temperature_tenths,
                          // below_zero, check_byte, pad
  logic [1:0]  m_tuser;   // status
  logic        cfg_valid;
  logic        cfg_ready;
  logic [15:0] cfg_data;  // bit_threshold

  sensor_frame_edge_decoder i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Bench copy of the decoder state
  logic [15:0] thresh;
  logic [6:0]  frame_edges;
  logic [31:0] last_stamp;
  logic [39:0] frame_shift;

  frame_report_t pending_reports[$];
  int            n_items;
  int            n_reports;
  int            n_mismatch;
  int            idle_cycles;
  int            burst_left;
  bit            tx_active;

  // Decode one accepted command; queue a report for end of frame
  function automatic void decode_command(input logic [1:0] cmd, input logic [31:0] stamp);
    logic [31:0]   interval;
    logic          one;
    logic [7:0]    tl;
    logic [7:0]    byte_sum;
    frame_report_t rep;
    case (cmd)
      CMD_START: begin
        frame_edges = '0;
        last_stamp  = '0;
        frame_shift = '0;
      end
      CMD_EDGE: begin
        if (frame_edges < MAX_EDGES) begin
          if (frame_edges >= FIRST_BIT_EDGE && frame_edges < FRAME_EDGES) begin
            interval    = stamp - last_stamp;
            // a negative interval always decodes as zero
            one         = !interval[31] && (interval >= {16'd0, thresh});
            frame_shift = {frame_shift[38:0], one};
          end
          last_stamp  = stamp;
          frame_edges = frame_edges + 7'd1;
        end
      end
      CMD_END: begin
        rep = '{status: STATUS_OK, edges_seen: frame_edges, humidity_whole: '0,
                humidity_tenths: '0, temperature_whole: '0, temperature_tenths: '0,
                below_zero: 1'b0, check_byte: '0};
        if (frame_edges != FRAME_EDGES) begin
          rep.status = STATUS_COUNT_ERR;
        end else begin
          tl                     = frame_shift[15:8];
          rep.humidity_whole     = frame_shift[39:32];
          rep.humidity_tenths    = frame_shift[31:24];
          rep.temperature_whole  = frame_shift[23:16];
          rep.temperature_tenths = tl[6:0];
          rep.below_zero         = tl[7];
          rep.check_byte         = frame_shift[7:0];
          byte_sum = frame_shift[39:32] + frame_shift[31:24] + frame_shift[23:16] + tl;
          if (byte_sum != frame_shift[7:0]) rep.status = STATUS_CHECKSUM_ERR;
        end
        pending_reports.push_back(rep);
        n_reports++;
      end
      default: ;
    endcase
  endfunction

  task automatic flag_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      if (n_mismatch < 10)
        $display("%0t: %s mismatch: expected %0d, got %0d", $realtime, name, want, got);
      n_mismatch++;
    end
  endtask

  // Compare one report transfer with the oldest expectation
  task automatic check_report(input logic [1:0] st, input logic [47:0] data);
    frame_report_t want;
    if (pending_reports.size() == 0) begin
      if (n_mismatch < 10)
        $display("%0t: report with none pending: status %0d data %h", $realtime, st, data);
      n_mismatch++;
    end else begin
      want = pending_reports.pop_front();
      flag_field("status", want.status, st);
      flag_field("edges_seen", want.edges_seen, data[6:0]);
      flag_field("humidity_whole", want.humidity_whole, data[14:7]);
      flag_field("humidity_tenths", want.humidity_tenths, data[22:15]);
      flag_field("temperature_whole", want.temperature_whole, data[30:23]);
      flag_field("temperature_tenths", want.temperature_tenths, data[37:31]);
      flag_field("below_zero", want.below_zero, data[38]);
      flag_field("check_byte", want.check_byte, data[46:39]);
    end
  endtask

  // Outputs and ready are sampled mid-cycle; inputs only move at the rising edge
  always @(negedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) check_report(m_tuser, m_tdata);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("sensor_frame_edge_decoder regression: fail");
        $finish;
      end
    end
  end

  // Receiver back-pressure: open, coin-flip and long-stall stretches
  rx_mode_t rx_mode = RX_OPEN;
  int       rx_left = 0;
  int       rx_stall = 0;
  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_mode <= rx_mode_t'($urandom_range(0, 2));
      rx_left <= $urandom_range(20, 200);
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_mode)
      RX_OPEN: m_tready <= 1'b1;
      RX_COIN: m_tready <= 1'($urandom_range(0, 1));
      default: begin
        if (rx_stall > 0) begin
          m_tready <= 1'b0;
          rx_stall <= rx_stall - 1;
        end else begin
          m_tready <= 1'b1;
          if ($urandom_range(0, 7) == 0) rx_stall <= $urandom_range(1, 25);
        end
      end
    endcase
  end

  task automatic go_idle();
    if (tx_active) begin
      s_tvalid  <= 1'b0;
      tx_active = 1'b0;
    end
  endtask

  // Send one item; returns at the rising edge of its transfer
  task automatic send_item(input logic [1:0] cmd, input logic [31:0] stamp);
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 30);
      go_idle();
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    burst_left--;
    s_tvalid  <= 1'b1;
    s_tuser   <= cmd;
    s_tdata   <= stamp;
    tx_active = 1'b1;
    do @(negedge clk); while (!s_tready);
    @(posedge clk);
    if (cmd != CMD_UNUSED) n_items++;
    decode_command(cmd, stamp);
  endtask

  // Threshold write once every report is out and the pipeline has drained
  task automatic set_threshold(input logic [15:0] value);
    go_idle();
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(negedge clk); while (!cfg_ready);
    @(posedge clk);
    cfg_valid <= 1'b0;
    thresh = value;
  endtask

  // Interval between edges that decodes to the wanted bit at the current threshold
  function automatic logic [31:0] interval_for_bit(input logic one);
    int unsigned th;
    th = 32'(thresh);
    if (one) begin
      if ($urandom_range(0, 3) == 0) return $urandom_range(th, 32'h7FFF_FFFF);
      return th + $urandom_range(0, 50);
    end
    if ($urandom_range(0, 7) == 0) return $urandom | 32'h8000_0000;
    return $urandom_range(0, th - 1);
  endfunction

  function automatic logic [39:0] random_frame_bits(input bit good_sum);
    logic [7:0] hu, hl, tu, tl, cb;
    hu = 8'($urandom);
    hl = 8'($urandom);
    tu = 8'($urandom);
    tl = 8'($urandom);
    cb = good_sum ? 8'(hu + hl + tu + tl) : 8'($urandom);
    return {hu, hl, tu, tl, cb};
  endfunction

  // Start, as many falling edges as n_edges asks, carrying the pattern MSB first, then optionally end
  task automatic send_frame(input logic [39:0] pattern, input int n_edges,
                            input bit finish, input bit noisy);
    logic [31:0] stamp;
    stamp = $urandom;
    send_item(CMD_START, $urandom);
    for (int i = 0; i < n_edges; i++) begin
      if (i == 0)
        stamp = $urandom;
      else if (i < 3)
        stamp = stamp + $urandom_range(0, 200);
      else if (i < 43)
        stamp = stamp + interval_for_bit(pattern[42 - i]);
      else
        stamp = stamp + $urandom;
      send_item(CMD_EDGE, stamp);
      if (noisy && $urandom_range(0, 7) == 0) send_item(CMD_UNUSED, $urandom);
    end
    if (finish) send_item(CMD_END, $urandom);
  endtask

  // Default threshold after reset, end before any start, a plain good frame
  task automatic test_reset_defaults();
    send_item(CMD_END, 32'd0);
    send_frame(random_frame_bits(1'b1), 43, 1'b1, 1'b0);
  endtask

  // Field extremes: all ones (bad sum, negative), all zeros, sign bit with good sum
  task automatic test_field_extremes();
    send_frame(40'hFF_FFFF_FFFF, 43, 1'b1, 1'b0);
    send_frame(40'h00_0000_0000, 43, 1'b1, 1'b0);
    send_frame(40'h01_0203_848A, 43, 1'b1, 1'b0);
  endtask

  // Edge-count errors, repeated end, ignored command, timestamp wraparound
  task automatic test_frame_errors();
    send_frame(random_frame_bits(1'b1), 42, 1'b1, 1'b0);
    send_frame(random_frame_bits(1'b1), 44, 1'b1, 1'b0);
    send_item(CMD_START, 32'hFFFF_FFFF);
    send_item(CMD_END, 32'hFFFF_FFFF);
    send_item(CMD_EDGE, 32'hFFFF_FFFF);
    send_item(CMD_UNUSED, 32'h5555_AAAA);
    send_item(CMD_EDGE, 32'h0000_0000);
    send_item(CMD_END, 32'h0000_0000);
    send_item(CMD_END, 32'hAAAA_5555);
    // end leaves the frame intact, so the repeated end reports the same count; then a noisy frame
    send_frame(random_frame_bits(1'b0), 43, 1'b1, 1'b1);
  endtask

  // Edges beyond the limit are dropped, also after an end
  task automatic test_edge_limit();
    send_frame(random_frame_bits(1'b1), 105, 1'b1, 1'b0);
    send_item(CMD_EDGE, $urandom);
    send_item(CMD_END, $urandom);
  endtask

  task automatic test_threshold_extremes();
    set_threshold(16'd1);
    send_frame(random_frame_bits(1'b1), 43, 1'b1, 1'b0);
    set_threshold(16'hFFFF);
    send_frame(random_frame_bits(1'b1), 43, 1'b1, 1'b0);
    send_frame(random_frame_bits(1'b0), 43, 1'b1, 1'b0);
    set_threshold(16'd100);
  endtask

  // Mostly well-formed frames, with broken frames, noise and threshold phases
  task automatic test_random_traffic();
    int          pick;
    int          phase_items;
    logic [15:0] th;
    phase_items = 0;
    while (n_items < ITEM_GOAL || n_reports < REPORT_GOAL) begin
      if (n_items - phase_items > 200) begin
        phase_items = n_items;
        case ($urandom_range(0, 4))
          0:       th = 16'd1;
          1:       th = 16'hFFFF;
          2:       th = 16'($urandom_range(1, 65535));
          3:       th = 16'($urandom_range(1, 300));
          default: th = 16'($urandom_range(50, 2000));
        endcase
        set_threshold(th);
      end
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        send_frame(random_frame_bits($urandom_range(0, 4) != 0), 43, 1'b1,
                   $urandom_range(0, 9) == 0);
      end else if (pick < 80) begin
        send_frame(random_frame_bits(1'b1), $urandom_range(0, 60), 1'b1, 1'b0);
      end else if (pick < 88) begin
        send_frame(random_frame_bits(1'b1), $urandom_range(0, 43), 1'b0, 1'b0);
        repeat ($urandom_range(1, 2)) send_item(CMD_END, $urandom);
      end else if (pick < 97) begin
        repeat ($urandom_range(1, 10)) send_item(2'($urandom_range(0, 3)), $urandom);
      end else begin
        send_frame(random_frame_bits(1'b1), $urandom_range(98, 110), 1'b1, 1'b0);
      end
    end
  endtask

  initial begin
    rst         <= 1'b1;
    s_tvalid    <= 1'b0;
    s_tdata     <= '0;
    s_tuser     <= CMD_START;
    cfg_valid   <= 1'b0;
    cfg_data    <= '0;
    thresh      = THRESH_RESET;
    frame_edges = '0;
    last_stamp  = '0;
    frame_shift = '0;
    n_items     = 0;
    n_reports   = 0;
    n_mismatch  = 0;
    idle_cycles = 0;
    burst_left  = 0;
    tx_active   = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    test_reset_defaults();
    test_field_extremes();
    test_frame_errors();
    test_edge_limit();
    test_threshold_extremes();
    test_random_traffic();

    // drain outstanding reports, then a short settle
    go_idle();
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (n_mismatch == 0 && pending_reports.size() == 0) begin
      $display("sensor_frame_edge_decoder regression: pass");
    end else begin
      $display("sensor_frame_edge_decoder regression: fail");
    end
    $finish;
  end

endmodule
